FILE: rtl/core/brsc_pkg.sv
// Shared constants and types for the bitmap rectangle set/clear/toggle block
package brsc_pkg;

    localparam int GRID_SIDE_DEF = 1024;
    localparam int WORD_BITS_DEF = 64;

    localparam int COORD_W = 10;
    localparam int MODE_W  = 2;
    localparam int LIT_W   = 21;

    localparam logic [LIT_W-1:0] LIT_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET    = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_INVERT = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic busy;
        logic issue;
    } walk_stat_t;

endpackage

FILE: rtl/core/brsc_cmd_if.sv
// Command channel: operation and rectangle corners
interface brsc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [brsc_pkg::MODE_W-1:0]   mode;
    logic [brsc_pkg::COORD_W-1:0]  x_first;
    logic [brsc_pkg::COORD_W-1:0]  y_first;
    logic [brsc_pkg::COORD_W-1:0]  x_last;
    logic [brsc_pkg::COORD_W-1:0]  y_last;

    modport source (
        output valid, mode, x_first, y_first, x_last, y_last,
        input  ready
    );

    modport sink (
        input  valid, mode, x_first, y_first, x_last, y_last,
        output ready
    );
endinterface

FILE: rtl/core/brsc_res_if.sv
// Result channel: count of set cells
interface brsc_res_if;
    logic                         valid;
    logic                         ready;
    logic [brsc_pkg::LIT_W-1:0]   lit_count;

    modport source (
        output valid, lit_count,
        input  ready
    );

    modport sink (
        input  valid, lit_count,
        output ready
    );
endinterface

FILE: rtl/core/brsc_ram.sv
// Generic single-write, single-read RAM with registered read data
module brsc_ram #(
    parameter  int WIDTH = brsc_pkg::WORD_BITS_DEF,
    parameter  int DEPTH = brsc_pkg::GRID_SIDE_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/brsc_walk.sv
// Address and mask sequencer: seeks the first word, then walks words row by row
module brsc_walk #(
    parameter  int GRID_SIDE = brsc_pkg::GRID_SIDE_DEF,
    parameter  int WORD_BITS = brsc_pkg::WORD_BITS_DEF,
    localparam int ROW_WORDS = (GRID_SIDE + WORD_BITS - 1) / WORD_BITS,
    localparam int DEPTH     = GRID_SIDE * ROW_WORDS,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [brsc_pkg::COORD_W-1:0]  x_first,
    input  logic [brsc_pkg::COORD_W-1:0]  y_first,
    input  logic [brsc_pkg::COORD_W-1:0]  x_last,
    input  logic [brsc_pkg::COORD_W-1:0]  y_last,
    output brsc_pkg::walk_stat_t          stat,
    output logic [AW-1:0]                 addr,
    output logic [WORD_BITS-1:0]          mask
);

    localparam int XW   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int WW   = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int BW   = $clog2(WORD_BITS);
    localparam int CW_A = $clog2(GRID_SIDE + WORD_BITS) + 1;
    localparam int CW   = (CW_A > brsc_pkg::COORD_W + 1) ? CW_A : brsc_pkg::COORD_W + 1;

    typedef enum logic [2:0] {
        W_IDLE = 3'b001,
        W_SEEK = 3'b010,
        W_RUN  = 3'b100
    } wstate_t;

    wstate_t         state_reg;
    wstate_t         state_next;

    logic [CW-1:0]   y0_reg;
    logic [CW-1:0]   y1_reg;
    logic [XW-1:0]   x_reg;
    logic [XW-1:0]   x1_reg;
    logic [WW-1:0]   w_reg;
    logic [WW-1:0]   w0_reg;
    logic [CW-1:0]   base_reg;
    logic [CW-1:0]   base0_reg;
    logic [AW-1:0]   row_addr_reg;

    logic [CW-1:0]   y0_in;
    logic [CW-1:0]   y1_raw;
    logic [CW-1:0]   y1_in;
    logic [CW-1:0]   x0_wide;
    logic [CW-1:0]   x1_raw;
    logic [CW-1:0]   x1_wide;
    logic [CW-1:0]   base_step;
    logic            seek_more;
    logic            row_end;
    logic [CW-1:0]   lo_full;
    logic [CW-1:0]   hi_full;
    logic [BW-1:0]   lo;
    logic [BW-1:0]   hi;

    always_comb
    begin
        y0_in   = CW'(y_first);
        y1_raw  = CW'(y_last);
        y1_in   = (y1_raw >= CW'(GRID_SIDE)) ? CW'(GRID_SIDE - 1) : y1_raw;
        x0_wide = CW'(x_first);
        x1_raw  = CW'(x_last);
        x1_wide = (x1_raw >= CW'(GRID_SIDE)) ? CW'(GRID_SIDE - 1) : x1_raw;

        base_step = base_reg + CW'(WORD_BITS);
        seek_more = (base_step <= y0_reg);
        row_end   = (base_step > y1_reg);

        lo_full = y0_reg - base_reg;
        hi_full = y1_reg - base_reg;
        lo      = (y0_reg > base_reg) ? lo_full[BW-1:0] : '0;
        hi      = row_end ? hi_full[BW-1:0] : BW'(WORD_BITS - 1);

        for (int b = 0; b < WORD_BITS; b++)
        begin
            mask[b] = (BW'(b) >= lo) && (BW'(b) <= hi);
        end

        addr = row_addr_reg + AW'(w_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    state_next = W_SEEK;
                end
            end
            W_SEEK:
            begin
                if (!seek_more)
                begin
                    state_next = W_RUN;
                end
            end
            W_RUN:
            begin
                if (row_end && (x_reg == x1_reg))
                begin
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            y0_reg       <= y0_in;
            y1_reg       <= y1_in;
            x_reg        <= x0_wide[XW-1:0];
            x1_reg       <= x1_wide[XW-1:0];
            w_reg        <= '0;
            base_reg     <= '0;
            row_addr_reg <= AW'(x0_wide) * AW'(ROW_WORDS);
        end
        else if (state_reg == W_SEEK)
        begin
            if (seek_more)
            begin
                w_reg    <= w_reg + WW'(1);
                base_reg <= base_step;
            end
            else
            begin
                w0_reg    <= w_reg;
                base0_reg <= base_reg;
            end
        end
        else if (state_reg == W_RUN)
        begin
            if (row_end)
            begin
                x_reg        <= x_reg + XW'(1);
                row_addr_reg <= row_addr_reg + AW'(ROW_WORDS);
                w_reg        <= w0_reg;
                base_reg     <= base0_reg;
            end
            else
            begin
                w_reg    <= w_reg + WW'(1);
                base_reg <= base_step;
            end
        end
    end

    assign stat.busy  = (state_reg != W_IDLE);
    assign stat.issue = (state_reg == W_RUN);

endmodule

FILE: rtl/core/brsc_tally.sv
// Running count of set cells: chunk popcounts, chunk sum, then accumulate
module brsc_tally #(
    parameter  int GRID_SIDE = brsc_pkg::GRID_SIDE_DEF,
    parameter  int WORD_BITS = brsc_pkg::WORD_BITS_DEF,
    localparam int TW_A      = $clog2(GRID_SIDE * GRID_SIDE + 1),
    localparam int TW        = (TW_A > brsc_pkg::LIT_W) ? TW_A : brsc_pkg::LIT_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] inc,
    input  logic [WORD_BITS-1:0] dec,
    output logic                 busy,
    output logic [TW-1:0]        total
);

    localparam int NCH = (WORD_BITS + 7) / 8;
    localparam int PW  = NCH * 8;
    localparam int SW  = $clog2(WORD_BITS + 1);

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    logic [PW-1:0]  inc_pad;
    logic [PW-1:0]  dec_pad;
    logic [3:0]     inc_part_reg [NCH];
    logic [3:0]     dec_part_reg [NCH];
    logic [SW-1:0]  inc_sum_next;
    logic [SW-1:0]  dec_sum_next;
    logic [SW-1:0]  inc_sum_reg;
    logic [SW-1:0]  dec_sum_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic [TW-1:0]  total_reg;

    assign inc_pad = PW'(inc);
    assign dec_pad = PW'(dec);

    always_comb
    begin
        inc_sum_next = '0;
        dec_sum_next = '0;
        for (int c = 0; c < NCH; c++)
        begin
            inc_sum_next = inc_sum_next + SW'(inc_part_reg[c]);
            dec_sum_next = dec_sum_next + SW'(dec_part_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NCH; c++)
        begin
            inc_part_reg[c] <= ones8(inc_pad[c*8 +: 8]);
            dec_part_reg[c] <= ones8(dec_pad[c*8 +: 8]);
        end
        inc_sum_reg <= inc_sum_next;
        dec_sum_reg <= dec_sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                total_reg <= total_reg + TW'(inc_sum_reg) - TW'(dec_sum_reg);
            end
        end
    end

    assign busy  = v1_reg | v2_reg;
    assign total = total_reg;

endmodule

FILE: rtl/core/bitmap_rect_set_clear_toggle.sv
// Top level: bitmap of one-bit cells updated by rectangle set/clear/invert commands
// Sequence: the walker seeks the first word, then updates one memory word per cycle over
//   the words touched (rows times words per row), then the update and count stages drain.
// Throughput: one word read-modify-write per cycle through the single bitmap RAM; a new
//   command is taken only after the previous result is loaded into the result register.
// Reset: count clears at once; a clearing pass over all GRID_SIDE*ROW_WORDS words
//   zeroes the RAM, and no command is taken until it finishes.
module bitmap_rect_set_clear_toggle #(
    parameter int GRID_SIDE = brsc_pkg::GRID_SIDE_DEF,
    parameter int WORD_BITS = brsc_pkg::WORD_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    brsc_cmd_if.sink   cmd,
    brsc_res_if.source res
);

    localparam int ROW_WORDS = (GRID_SIDE + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH     = GRID_SIDE * ROW_WORDS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW_A      = $clog2(GRID_SIDE * GRID_SIDE + 1);
    localparam int TW        = (TW_A > brsc_pkg::LIT_W) ? TW_A : brsc_pkg::LIT_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [AW-1:0]                  clr_addr_reg;
    brsc_pkg::mode_t                mode_reg;
    logic                           b_valid_reg;
    logic [AW-1:0]                  b_addr_reg;
    logic [WORD_BITS-1:0]           b_mask_reg;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    logic [brsc_pkg::LIT_W-1:0]     res_data_reg;

    logic                           accept;
    logic                           act;
    logic                           load_res;
    brsc_pkg::walk_stat_t           walk_stat;
    logic [AW-1:0]                  walk_addr;
    logic [WORD_BITS-1:0]           walk_mask;
    logic [WORD_BITS-1:0]           old_word;
    logic [WORD_BITS-1:0]           new_word;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [WORD_BITS-1:0]           ram_wdata;
    logic                           tally_busy;
    logic [TW-1:0]                  total;
    logic [brsc_pkg::LIT_W-1:0]     lit_sat;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    assign act = (cmd.mode != brsc_pkg::MODE_NONE)
                 && (cmd.x_last >= cmd.x_first)
                 && (cmd.y_last >= cmd.y_first)
                 && (int'(cmd.x_first) < GRID_SIDE)
                 && (int'(cmd.y_first) < GRID_SIDE);

    assign load_res = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

    brsc_walk #(
        .GRID_SIDE (GRID_SIDE),
        .WORD_BITS (WORD_BITS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && act),
        .x_first (cmd.x_first),
        .y_first (cmd.y_first),
        .x_last  (cmd.x_last),
        .y_last  (cmd.y_last),
        .stat    (walk_stat),
        .addr    (walk_addr),
        .mask    (walk_mask)
    );

    always_comb
    begin
        case (mode_reg)
            brsc_pkg::MODE_SET:    new_word = old_word | b_mask_reg;
            brsc_pkg::MODE_CLEAR:  new_word = old_word & ~b_mask_reg;
            brsc_pkg::MODE_INVERT: new_word = old_word ^ b_mask_reg;
            default:               new_word = old_word;
        endcase
    end

    assign ram_we    = (state_reg == ST_CLEAR) || b_valid_reg;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : b_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : new_word;

    brsc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (walk_addr),
        .rdata (old_word)
    );

    brsc_tally #(
        .GRID_SIDE (GRID_SIDE),
        .WORD_BITS (WORD_BITS)
    ) u_tally (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (b_valid_reg),
        .inc      (new_word & ~old_word),
        .dec      (old_word & ~new_word),
        .busy     (tally_busy),
        .total    (total)
    );

    assign lit_sat = (total > TW'(brsc_pkg::LIT_MAX)) ? brsc_pkg::LIT_MAX
                                                      : total[brsc_pkg::LIT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = act ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (!walk_stat.busy)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!b_valid_reg && !tally_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_res)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !res.ready;
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            b_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_valid_reg   <= walk_stat.issue;
            res_valid_reg <= res_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_addr_reg <= walk_addr;
        b_mask_reg <= walk_mask;
        if (accept)
        begin
            mode_reg <= brsc_pkg::mode_t'(cmd.mode);
        end
        if (load_res)
        begin
            res_data_reg <= lit_sat;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.lit_count = res_data_reg;

endmodule

FILE: rtl/core/brsc_check.sv
// Port-level checks for the bitmap rectangle block, bound to the top level
module brsc_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [brsc_pkg::LIT_W-1:0]  lit_count
);

    a_busy_after_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready
    ) else $error("command port stayed ready after taking a word");

    a_res_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(lit_count))
    ) else $error("stalled result word changed or dropped");

    a_res_with_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> cmd_ready
    ) else $error("result word appeared while command still in progress");

    a_clear_pass: assert property (
        @(posedge clk)
        $rose(rst_n) |-> !cmd_ready
    ) else $error("command port ready before clearing pass");

endmodule

bind bitmap_rect_set_clear_toggle brsc_check u_brsc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .lit_count (res.lit_count)
);

FILE: verif/bitmap_rect_set_clear_toggle_tb.sv
// Testbench for bitmap_rect_set_clear_toggle: rectangle commands checked against a bitmap tracker
module bitmap_rect_set_clear_toggle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE        = brsc_pkg::GRID_SIDE_DEF;
    localparam int COORD_W     = brsc_pkg::COORD_W;
    localparam int LIT_W       = brsc_pkg::LIT_W;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int QUIET_LIMIT = 100000;
    localparam int ITEM_GOAL   = 100;

    typedef struct packed {
        brsc_pkg::mode_t    mode;
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] x_last;
        logic [COORD_W-1:0] y_last;
    } rect_cmd_t;

    class lit_tracker_t;
        bit [SIDE-1:0]    cells [SIDE];
        longint           set_cells;
        logic [LIT_W-1:0] expected_counts [$];
        int               results_seen;
        int               errors;

        function new();
            foreach (cells[i])
                cells[i] = '0;
            set_cells    = 0;
            results_seen = 0;
            errors       = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function void note_command(brsc_pkg::mode_t op, int x0, int y0, int x1, int y1);
            bit [SIDE-1:0] all_ones;
            bit [SIDE-1:0] span;
            bit [SIDE-1:0] was;
            bit [SIDE-1:0] now_row;
            all_ones = '1;
            if (op != brsc_pkg::MODE_NONE && x1 >= x0 && y1 >= y0 && x0 < SIDE && y0 < SIDE)
            begin
                if (x1 >= SIDE)
                    x1 = SIDE - 1;
                if (y1 >= SIDE)
                    y1 = SIDE - 1;
                span = (all_ones >> (SIDE - 1 - (y1 - y0))) << y0;
                for (int x = x0; x <= x1; x++)
                begin
                    was = cells[x];
                    case (op)
                        brsc_pkg::MODE_SET:   now_row = was | span;
                        brsc_pkg::MODE_CLEAR: now_row = was & ~span;
                        default:              now_row = was ^ span;
                    endcase
                    set_cells += $countones(now_row & span) - $countones(was & span);
                    cells[x] = now_row;
                end
            end
            if (set_cells > longint'(brsc_pkg::LIT_MAX))
                expected_counts.push_back(brsc_pkg::LIT_MAX);
            else
                expected_counts.push_back(set_cells[LIT_W-1:0]);
        endfunction

        task check_count(logic [LIT_W-1:0] got);
            logic [LIT_W-1:0] want;
            results_seen++;
            if (expected_counts.size() == 0)
                report($sformatf("lit_count %0d with no command waiting", got));
            else
            begin
                want = expected_counts.pop_front();
                if (got !== want)
                    report($sformatf("lit_count got %0d expected %0d", got, want));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    brsc_cmd_if cmd ();
    brsc_res_if res ();

    bitmap_rect_set_clear_toggle dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    lit_tracker_t board = new();
    int           burst_left = 0;
    int           items_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
                board.note_command(brsc_pkg::mode_t'(cmd.mode), cmd.x_first, cmd.y_first,
                                   cmd.x_last, cmd.y_last);
            if (res.valid && res.ready)
                board.check_count(res.lit_count);
        end
    end

    function automatic rect_cmd_t rect(brsc_pkg::mode_t m, int x0, int y0, int x1, int y1);
        rect_cmd_t c;
        c.mode    = m;
        c.x_first = x0[COORD_W-1:0];
        c.y_first = y0[COORD_W-1:0];
        c.x_last  = x1[COORD_W-1:0];
        c.y_last  = y1[COORD_W-1:0];
        return c;
    endfunction

    function automatic rect_cmd_t random_rect();
        int              pick;
        int              x0;
        int              y0;
        int              h;
        int              w;
        brsc_pkg::mode_t m;
        pick = $urandom_range(0, 99);
        m    = brsc_pkg::mode_t'($urandom_range(0, 2));
        if (pick < 10)
            return rect(brsc_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX));
        if (pick < 18)
            return rect(brsc_pkg::MODE_NONE, $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX));
        if (pick < 21)
            return rect(m, $urandom_range(0, 3), $urandom_range(0, 3),
                        $urandom_range(COORD_MAX - 3, COORD_MAX),
                        $urandom_range(COORD_MAX - 3, COORD_MAX));
        x0 = $urandom_range(0, COORD_MAX);
        y0 = $urandom_range(0, COORD_MAX);
        h  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
        w  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 70);
        return rect(m, x0, y0, (x0 + h > COORD_MAX) ? COORD_MAX : x0 + h,
                    (y0 + w > COORD_MAX) ? COORD_MAX : y0 + w);
    endfunction

    task automatic offer(rect_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd.valid   <= 1'b1;
        cmd.mode    <= c.mode;
        cmd.x_first <= c.x_first;
        cmd.y_first <= c.y_first;
        cmd.x_last  <= c.x_last;
        cmd.y_last  <= c.y_last;
        do
            @(posedge clk);
        while (!cmd.ready);
        items_sent++;
    endtask

    task automatic run_directed();
        offer(rect(brsc_pkg::MODE_SET, 0, 0, 0, 0));
        offer(rect(brsc_pkg::MODE_SET, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        offer(rect(brsc_pkg::MODE_INVERT, 0, 0, COORD_MAX, COORD_MAX));
        offer(rect(brsc_pkg::MODE_SET, 0, 0, COORD_MAX, COORD_MAX));
        offer(rect(brsc_pkg::MODE_NONE, 0, 0, COORD_MAX, COORD_MAX));
        offer(rect(brsc_pkg::MODE_CLEAR, 0, 0, COORD_MAX, COORD_MAX));
        offer(rect(brsc_pkg::MODE_SET, 5, 63, 9, 64));
        offer(rect(brsc_pkg::MODE_SET, 100, 0, 100, COORD_MAX));
        offer(rect(brsc_pkg::MODE_INVERT, 0, 512, COORD_MAX, 512));
        offer(rect(brsc_pkg::MODE_SET, 10, 20, 9, 40));
        offer(rect(brsc_pkg::MODE_INVERT, 30, 700, 40, 3));
        offer(rect(brsc_pkg::MODE_INVERT, 200, 64, 203, 127));
        offer(rect(brsc_pkg::MODE_SET, 341, 682, 682, COORD_MAX));
        offer(rect(brsc_pkg::MODE_CLEAR, 0, 0, COORD_MAX, 63));
        offer(rect(brsc_pkg::MODE_NONE, 700, 700, 3, 3));
        offer(rect(brsc_pkg::MODE_CLEAR, COORD_MAX, 0, COORD_MAX, 0));
        offer(rect(brsc_pkg::MODE_INVERT, 682, 341, 690, 341));
        offer(rect(brsc_pkg::MODE_CLEAR, 341, 700, 400, 1000));
    endtask

    initial
    begin : stimulus
        rst_n       = 1'b0;
        cmd.valid   <= 1'b0;
        cmd.mode    <= brsc_pkg::MODE_SET;
        cmd.x_first <= '0;
        cmd.y_first <= '0;
        cmd.x_last  <= '0;
        cmd.y_last  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (items_sent < ITEM_GOAL)
            offer(random_rect());
        cmd.valid <= 1'b0;
        while (board.results_seen < items_sent)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("PASS bitmap_rect_set_clear_toggle");
        else
            $display("FAIL bitmap_rect_set_clear_toggle");
        $finish;
    end

    initial
    begin : rx_pattern
        int stretch_left;
        int stall_style;
        bit held_off;
        bit rdy;
        stretch_left = 0;
        stall_style  = 0;
        held_off     = 1'b0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held_off && board.results_seen >= 30)
            begin
                held_off = 1'b1;
                res.ready <= 1'b0;
                repeat (800) @(posedge clk);
            end
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(16, 96);
                stall_style  = $urandom_range(0, 2);
            end
            stretch_left--;
            case (stall_style)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(0, 3) != 0);
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
            res.ready <= rdy;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL bitmap_rect_set_clear_toggle");
        $finish;
    end

endmodule
